// File: rtl/glc_pkg.sv
// ----------------------------------------------------------------------------
// glc_pkg: shared definitions for the gate-scaled LSTM cell
// Sizes, item codes, ring cell control and the activation point tables.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int HiddenSize  = 32;
  localparam int InputSize   = 32;
  localparam int DataWidth   = 16;
  localparam int NumGates    = 4;
  localparam int GateRows    = NumGates * HiddenSize;
  localparam int RowLen      = InputSize + HiddenSize;
  localparam int WeightDepth = GateRows * RowLen;
  localparam int BiasDepth   = 2 * GateRows;
  localparam int ActWidth    = 14;

  typedef enum logic [2:0] {
    OP_WEIGHT = 3'd0,
    OP_BIAS   = 3'd1,
    OP_HIDDEN = 3'd2,
    OP_CELL   = 3'd3,
    OP_INPUT  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_SCALE_I = 2'd0,
    CFG_SCALE_F = 2'd1,
    CFG_SCALE_G = 2'd2,
    CFG_SCALE_O = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic shift;
    logic load_h;
    logic load_c;
  } cell_ctrl_t;

  // sigmoid(m/4) in Q2.12 for m = 0..32
  function automatic logic signed [ActWidth-1:0] sig_mag(input logic [5:0] m);
    logic signed [ActWidth-1:0] v;
    case (m)
      6'd0:  v = 14'sd2048;
      6'd1:  v = 14'sd2303;
      6'd2:  v = 14'sd2550;
      6'd3:  v = 14'sd2782;
      6'd4:  v = 14'sd2994;
      6'd5:  v = 14'sd3184;
      6'd6:  v = 14'sd3349;
      6'd7:  v = 14'sd3490;
      6'd8:  v = 14'sd3608;
      6'd9:  v = 14'sd3705;
      6'd10: v = 14'sd3785;
      6'd11: v = 14'sd3850;
      6'd12: v = 14'sd3902;
      6'd13: v = 14'sd3943;
      6'd14: v = 14'sd3976;
      6'd15: v = 14'sd4002;
      6'd16: v = 14'sd4022;
      6'd17: v = 14'sd4038;
      6'd18: v = 14'sd4051;
      6'd19: v = 14'sd4061;
      6'd20: v = 14'sd4069;
      6'd21: v = 14'sd4075;
      6'd22: v = 14'sd4079;
      6'd23: v = 14'sd4083;
      6'd24: v = 14'sd4086;
      6'd25: v = 14'sd4088;
      6'd26: v = 14'sd4090;
      6'd27: v = 14'sd4091;
      6'd28: v = 14'sd4092;
      6'd29: v = 14'sd4093;
      6'd30: v = 14'sd4094;
      6'd31: v = 14'sd4094;
      default: v = 14'sd4095;
    endcase
    return v;
  endfunction

  // tanh(m/4) in Q2.12; saturated at one from m = 20 up
  function automatic logic signed [ActWidth-1:0] tanh_mag(input logic [5:0] m);
    logic signed [ActWidth-1:0] v;
    case (m)
      6'd0:  v = 14'sd0;
      6'd1:  v = 14'sd1003;
      6'd2:  v = 14'sd1893;
      6'd3:  v = 14'sd2602;
      6'd4:  v = 14'sd3119;
      6'd5:  v = 14'sd3475;
      6'd6:  v = 14'sd3707;
      6'd7:  v = 14'sd3856;
      6'd8:  v = 14'sd3949;
      6'd9:  v = 14'sd4006;
      6'd10: v = 14'sd4041;
      6'd11: v = 14'sd4062;
      6'd12: v = 14'sd4076;
      6'd13: v = 14'sd4084;
      6'd14: v = 14'sd4089;
      6'd15: v = 14'sd4091;
      6'd16: v = 14'sd4093;
      6'd17: v = 14'sd4094;
      6'd18: v = 14'sd4095;
      6'd19: v = 14'sd4095;
      default: v = 14'sd4096;
    endcase
    return v;
  endfunction

  // table point k sits at -8 + k/4
  function automatic logic signed [ActWidth-1:0] sig_point(input logic [6:0] k);
    logic [6:0] m;
    if (k >= 7'd32) begin
      m = k - 7'd32;
      return sig_mag(m[5:0]);
    end
    m = 7'd32 - k;
    return 14'sd4096 - sig_mag(m[5:0]);
  endfunction

  function automatic logic signed [ActWidth-1:0] tanh_point(input logic [6:0] k);
    logic [6:0] m;
    if (k >= 7'd32) begin
      m = k - 7'd32;
      return tanh_mag(m[5:0]);
    end
    m = 7'd32 - k;
    return -tanh_mag(m[5:0]);
  endfunction

  function automatic logic signed [DataWidth-1:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[DataWidth-1:0];
  endfunction

endpackage

// File: rtl/glc_ram.sv
// ----------------------------------------------------------------------------
// glc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module glc_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/glc_cell.sv
// ----------------------------------------------------------------------------
// glc_cell: one hidden unit of the state ring
// Holds one hidden and one cell element, shifts toward the head.
// ----------------------------------------------------------------------------
module glc_cell
  import glc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cell_ctrl_t                  ctrl_i,
  input  logic signed [DataWidth-1:0] load_val_i,
  input  logic signed [DataWidth-1:0] h_nbr_i,
  input  logic signed [DataWidth-1:0] c_nbr_i,
  output logic signed [DataWidth-1:0] h_o,
  output logic signed [DataWidth-1:0] c_o
);

  logic signed [DataWidth-1:0] h_q, h_d, c_q, c_d;

  always_comb begin
    h_d = h_q;
    c_d = c_q;
    if (ctrl_i.shift) begin
      h_d = h_nbr_i;
      c_d = c_nbr_i;
    end else begin
      if (ctrl_i.load_h) begin
        h_d = load_val_i;
      end
      if (ctrl_i.load_c) begin
        c_d = load_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
      c_q <= '0;
    end else begin
      h_q <= h_d;
      c_q <= c_d;
    end
  end

  assign h_o = h_q;
  assign c_o = c_q;

endmodule

// File: rtl/glc_act.sv
// ----------------------------------------------------------------------------
// glc_act: piecewise-linear sigmoid / tanh
// 64 segments over [-8, 8), linear interpolation, registered result.
// ----------------------------------------------------------------------------
module glc_act
  import glc_pkg::*;
(
  input  logic                        clk_i,
  input  logic signed [DataWidth-1:0] z_i,
  input  logic                        tanh_i,
  output logic signed [DataWidth-1:0] y_o
);

  logic [DataWidth-1:0]         u;
  logic [6:0]                   k0, k1;
  logic signed [ActWidth-1:0]   t0, t1;
  logic signed [ActWidth:0]     d;
  logic signed [10:0]           frac;
  logic signed [25:0]           p, pr;
  logic signed [DataWidth-1:0]  y_d;

  always_comb begin
    u    = {~z_i[DataWidth-1], z_i[DataWidth-2:0]};
    k0   = {1'b0, u[15:10]};
    k1   = k0 + 7'd1;
    t0   = tanh_i ? tanh_point(k0) : sig_point(k0);
    t1   = tanh_i ? tanh_point(k1) : sig_point(k1);
    d    = {t1[ActWidth-1], t1} - {t0[ActWidth-1], t0};
    frac = $signed({1'b0, u[9:0]});
    p    = d * frac;
    pr   = p + 26'sd512;
    y_d  = {{2{t0[ActWidth-1]}}, t0} + pr[25:10];
  end

  always_ff @(posedge clk_i) begin
    y_o <= y_d;
  end

endmodule

// File: rtl/gate_scaled_lstm_cell.sv
// ----------------------------------------------------------------------------
// gate_scaled_lstm_cell: Q4.12 LSTM cell with per-gate recurrent scale
// Load and feed items, one shared MAC, state held in a ring of unit cells.
// ----------------------------------------------------------------------------
// Load items (weights, biases, initial hidden/cell, input elements) are taken
// whenever the block is idle. An input element marked last starts a time
// step: the single multiply-accumulate unit walks the 128 gate rows, each row
// being two bias reads, 64 weight reads from the weight RAM, scale, round and
// activate, while the hidden vector rotates past the MAC through the ring of
// unit cells. The update pass then handles each of the 32 units in turn and
// waits on any output stall. No item is accepted during a step.
// Hidden and cell are cleared by reset; weight, bias and input stores hold
// garbage until written.
module gate_scaled_lstm_cell
  import glc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [DataWidth-1:0]        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  opcode_i,
  input  logic [6:0]                  gate_row_i,
  input  logic [5:0]                  column_i,
  input  logic signed [DataWidth-1:0] value_i,
  input  logic                        last_element_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DataWidth-1:0] hidden_value_o,
  output logic signed [DataWidth-1:0] cell_value_o,
  output logic [4:0]                  unit_index_o,
  output logic                        last_unit_o
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'd1,
    S_BX    = 18'd2,
    S_BH    = 18'd4,
    S_BW    = 18'd8,
    S_MAC   = 18'd16,
    S_DRAIN = 18'd32,
    S_SCALE = 18'd64,
    S_SUM   = 18'd128,
    S_ACT   = 18'd256,
    S_ACTW  = 18'd512,
    S_URD   = 18'd1024,
    S_UDR   = 18'd2048,
    S_UC1   = 18'd4096,
    S_UC2   = 18'd8192,
    S_UC3   = 18'd16384,
    S_UT    = 18'd32768,
    S_UH    = 18'd65536,
    S_OUT   = 18'd131072
  } state_e;

  state_e state_q, state_d;

  logic [6:0] row_q, row_d;
  logic [5:0] col_q, col_d, dcol_q, dcol_d;
  logic       dv_q, dv_d;
  logic [4:0] j_q, j_d;
  logic [1:0] g_q, g_d, dg_q, dg_d;

  logic signed [43:0] ax_q, ax_d;
  logic signed [39:0] ah_q, ah_d;
  logic signed [55:0] sp_q, sp_d;
  logic signed [31:0] p1_q, p1_d;
  logic signed [31:0] cacc_q, cacc_d;
  logic signed [DataWidth-1:0] c_q, c_d, h_q, h_d;
  logic signed [ActWidth-1:0]  gate_q [NumGates];
  logic signed [DataWidth-1:0] scale_q [NumGates];
  logic signed [DataWidth-1:0] xbuf_q [InputSize];

  logic in_acc;
  logic w_we, b_we, a_we;
  logic [DataWidth-1:0] w_rdata, b_rdata;
  logic [ActWidth-1:0]  a_rdata;
  logic [7:0]           b_raddr;

  logic signed [DataWidth-1:0] mac_b;
  logic signed [31:0]          mac_p;
  logic signed [55:0]          spr;
  logic signed [43:0]          axr;
  logic signed [31:0]          cr, hp, hr;
  logic signed [DataWidth-1:0] z_x, act_z, act_y;
  logic                        act_tanh;

  cell_ctrl_t                  cell_ctrl [HiddenSize];
  logic signed [DataWidth-1:0] h_chain [HiddenSize+1];
  logic signed [DataWidth-1:0] c_chain [HiddenSize+1];
  logic                        ring_shift;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumGates; i++) begin
        scale_q[i] <= 16'sd4096;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCALE_I: scale_q[0] <= cfg_data_i;
        CFG_SCALE_F: scale_q[1] <= cfg_data_i;
        CFG_SCALE_G: scale_q[2] <= cfg_data_i;
        CFG_SCALE_O: scale_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input element buffer
  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i == OP_INPUT && !column_i[5]) begin
      xbuf_q[column_i[4:0]] <= value_i;
    end
  end

  assign w_we = in_acc && (opcode_i == OP_WEIGHT);
  assign b_we = in_acc && (opcode_i == OP_BIAS) && (column_i[5:1] == 5'd0);
  assign a_we = (state_q == S_ACTW);
  assign b_raddr = {(state_q == S_BH), row_q};

  glc_ram #(.Width(DataWidth), .Depth(WeightDepth)) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i ({gate_row_i, column_i}),
    .wdata_i (value_i),
    .raddr_i ({row_q, col_q}),
    .rdata_o (w_rdata)
  );

  glc_ram #(.Width(DataWidth), .Depth(BiasDepth)) u_bram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i ({column_i[0], gate_row_i}),
    .wdata_i (value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  glc_ram #(.Width(ActWidth), .Depth(GateRows)) u_aram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (row_q),
    .wdata_i (act_y[ActWidth-1:0]),
    .raddr_i ({g_q, j_q}),
    .rdata_o (a_rdata)
  );

  // state ring, head (cell 0) is the unit in use
  assign ring_shift = ((state_q == S_MAC || state_q == S_DRAIN) && dv_q && dcol_q[5])
                    || (state_q == S_OUT && !out_stall_i);
  assign h_chain[HiddenSize] = (state_q == S_OUT) ? h_q : h_chain[0];
  assign c_chain[HiddenSize] = (state_q == S_OUT) ? c_q : c_chain[0];

  for (genvar i = 0; i < HiddenSize; i++) begin : g_ring
    always_comb begin
      cell_ctrl[i].shift  = ring_shift;
      cell_ctrl[i].load_h = in_acc && (opcode_i == OP_HIDDEN)
                            && (gate_row_i == 7'(i));
      cell_ctrl[i].load_c = in_acc && (opcode_i == OP_CELL)
                            && (gate_row_i == 7'(i));
    end

    glc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl[i]),
      .load_val_i (value_i),
      .h_nbr_i    (h_chain[i+1]),
      .c_nbr_i    (c_chain[i+1]),
      .h_o        (h_chain[i]),
      .c_o        (c_chain[i])
    );
  end

  // activation unit shared by gates and cell tanh
  assign axr      = ax_q + 44'sd2048;
  assign z_x      = sat16(axr[43:12]);
  assign act_tanh = (state_q == S_UT);
  assign act_z    = act_tanh ? c_q : z_x;

  glc_act u_act (
    .clk_i  (clk_i),
    .z_i    (act_z),
    .tanh_i (act_tanh),
    .y_o    (act_y)
  );

  assign mac_b = dcol_q[5] ? h_chain[0] : xbuf_q[dcol_q[4:0]];
  assign mac_p = $signed(w_rdata) * mac_b;
  assign spr   = sp_q + 56'sd2048;
  assign cr    = cacc_q + 32'sd2048;
  assign hp    = gate_q[3] * act_y;
  assign hr    = hp + 32'sd2048;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    dcol_d  = dcol_q;
    dv_d    = 1'b0;
    j_d     = j_q;
    g_d     = g_q;
    dg_d    = dg_q;
    ax_d    = ax_q;
    ah_d    = ah_q;
    sp_d    = sp_q;
    p1_d    = p1_q;
    cacc_d  = cacc_q;
    c_d     = c_q;
    h_d     = h_q;

    if ((state_q == S_MAC || state_q == S_DRAIN) && dv_q) begin
      if (dcol_q[5]) begin
        ah_d = ah_q + {{8{mac_p[31]}}, mac_p};
      end else begin
        ax_d = ax_q + {{12{mac_p[31]}}, mac_p};
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && opcode_i == OP_INPUT && last_element_i) begin
          row_d   = '0;
          state_d = S_BX;
        end
      end
      S_BX: state_d = S_BH;
      S_BH: begin
        ax_d    = {{16{b_rdata[15]}}, b_rdata, 12'd0};
        state_d = S_BW;
      end
      S_BW: begin
        ah_d    = {{12{b_rdata[15]}}, b_rdata, 12'd0};
        col_d   = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        dv_d   = 1'b1;
        dcol_d = col_q;
        col_d  = col_q + 6'd1;
        if (col_q == 6'(RowLen - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_SCALE;
      S_SCALE: begin
        sp_d    = ah_q * scale_q[row_q[6:5]];
        state_d = S_SUM;
      end
      S_SUM: begin
        ax_d    = ax_q + spr[55:12];
        state_d = S_ACT;
      end
      S_ACT: state_d = S_ACTW;
      S_ACTW: begin
        if (row_q == 7'(GateRows - 1)) begin
          j_d     = '0;
          g_d     = '0;
          state_d = S_URD;
        end else begin
          row_d   = row_q + 7'd1;
          state_d = S_BX;
        end
      end
      S_URD: begin
        dv_d = 1'b1;
        dg_d = g_q;
        g_d  = g_q + 2'd1;
        if (g_q == 2'(NumGates - 1)) begin
          state_d = S_UDR;
        end
      end
      S_UDR: state_d = S_UC1;
      S_UC1: begin
        p1_d    = gate_q[1] * c_chain[0];
        state_d = S_UC2;
      end
      S_UC2: begin
        cacc_d  = p1_q + gate_q[0] * gate_q[2];
        state_d = S_UC3;
      end
      S_UC3: begin
        c_d     = sat16({{12{cr[31]}}, cr[31:12]});
        state_d = S_UT;
      end
      S_UT: state_d = S_UH;
      S_UH: begin
        h_d     = sat16({{12{hr[31]}}, hr[31:12]});
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (j_q == 5'(HiddenSize - 1)) begin
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + 5'd1;
            g_d     = '0;
            state_d = S_URD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // gate capture for the update pass
  always_ff @(posedge clk_i) begin
    if ((state_q == S_URD || state_q == S_UDR) && dv_q) begin
      gate_q[dg_q] <= $signed(a_rdata);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      dcol_q  <= '0;
      dv_q    <= 1'b0;
      j_q     <= '0;
      g_q     <= '0;
      dg_q    <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      dcol_q  <= dcol_d;
      dv_q    <= dv_d;
      j_q     <= j_d;
      g_q     <= g_d;
      dg_q    <= dg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ah_q   <= ah_d;
    sp_q   <= sp_d;
    p1_q   <= p1_d;
    cacc_q <= cacc_d;
    c_q    <= c_d;
    h_q    <= h_d;
  end

  assign out_valid_o    = (state_q == S_OUT);
  assign hidden_value_o = h_q;
  assign cell_value_o   = c_q;
  assign unit_index_o   = j_q;
  assign last_unit_o    = (j_q == 5'(HiddenSize - 1));

endmodule

// File: rtl/glc_checker.sv
// ----------------------------------------------------------------------------
// glc_checker: port-level checks for the gate-scaled LSTM cell
// Watches the item channels of the top level over time.
// ----------------------------------------------------------------------------
module glc_checker
  import glc_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [DataWidth-1:0] hidden_value_o,
  input logic signed [DataWidth-1:0] cell_value_o,
  input logic [4:0]                  unit_index_o,
  input logic                        last_unit_o
);

  // no new item while results of a step are pending
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while results pending");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_unit_o == (unit_index_o == 5'd31)))
    else $error("last_unit does not match unit_index");

  a_step_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_unit_o) |=> !out_valid_o)
    else $error("result after last unit");

  a_mid_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_unit_o) |=> in_stall_o)
    else $error("input opened before step finished");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(hidden_value_o)
      && $stable(cell_value_o) && $stable(unit_index_o)))
    else $error("stalled result changed");

endmodule

bind gate_scaled_lstm_cell glc_checker u_glc_checker (.*);

// File: bench/gate_scaled_lstm_cell_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gate_scaled_lstm_cell_checker: predicts and checks the LSTM cell results
// Watches the config port and both channels, keeps its own copy of the
// weights, biases, state vectors and gate scales, computes every time step
// in Q4.12 and compares each emitted unit result with the oldest prediction.
// ----------------------------------------------------------------------------
module gate_scaled_lstm_cell_checker
  import glc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [DataWidth-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [2:0]           opcode_i,
  input  logic [6:0]           gate_row_i,
  input  logic [5:0]           column_i,
  input  logic [15:0]          value_i,
  input  logic                 last_element_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [15:0]          hidden_value_i,
  input  logic [15:0]          cell_value_i,
  input  logic [4:0]           unit_index_i,
  input  logic                 last_unit_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef longint unsigned u64_t;

  localparam int Segments = 64;
  localparam int SegShift = 10;  // 65536 / Segments = 1 << SegShift
  localparam u64_t Q30One = 64'd1 << 30;

  typedef struct {
    logic [15:0] hidden;
    logic [15:0] cell_val;
    logic [4:0]  unit;
    logic        last;
  } unit_result_t;

  logic signed [15:0] weights [WeightDepth];
  logic signed [15:0] biases  [BiasDepth];
  logic signed [15:0] h_vec   [HiddenSize];
  logic signed [15:0] c_vec   [HiddenSize];
  logic signed [15:0] x_buf   [InputSize];
  logic signed [15:0] gate_scale [NumGates];
  longint sig_tab  [Segments+1];
  longint tanh_tab [Segments+1];
  unit_result_t unit_results_q [$];

  // e^-x, x in Q30 within [0,1], by Taylor series
  function automatic u64_t exp_frac(input u64_t x);
    u64_t term;
    longint sum;
    term = Q30One;
    sum = longint'(Q30One);
    for (int i = 1; i <= 24; i++) begin
      term = ((term * x) >> 30) / u64_t'(i);
      if (i % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return (sum < 0) ? 0 : u64_t'(sum);
  endfunction

  // e^-m, m in unsigned Q4.12, result in Q30
  function automatic u64_t exp_neg_q12(input u64_t m);
    u64_t r;
    u64_t e1;
    r = exp_frac((m & 64'd4095) << 18);
    e1 = exp_frac(Q30One);
    for (u64_t k = 0; k < (m >> 12); k++) r = (r * e1) >> 30;
    return r;
  endfunction

  function automatic longint table_point(input bit is_tanh, input longint p);
    u64_t a, e, d;
    longint v;
    a = (p < 0) ? u64_t'(-p) : u64_t'(p);
    e = exp_neg_q12(is_tanh ? 2 * a : a);
    d = Q30One + e;
    if (is_tanh) begin
      v = longint'(((Q30One - e) * 4096 + d / 2) / d);
      return (p < 0) ? -v : v;
    end
    v = longint'((Q30One * 4096 + d / 2) / d);
    return (p < 0) ? 4096 - v : v;
  endfunction

  function automatic longint clamp16(input longint v);
    return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
  endfunction

  function automatic longint rnd_q12(input longint v);
    return (v + 2048) >>> 12;
  endfunction

  function automatic longint activate(input bit is_tanh, input longint z);
    longint u, k, lo, t0, t1;
    u = clamp16(z) + 32768;
    k = u >>> SegShift;
    lo = k <<< SegShift;
    t0 = is_tanh ? tanh_tab[k] : sig_tab[k];
    t1 = is_tanh ? tanh_tab[k+1] : sig_tab[k+1];
    return t0 + (((t1 - t0) * (u - lo) + (1 << (SegShift - 1))) >>> SegShift);
  endfunction

  initial begin
    for (int k = 0; k <= Segments; k++) begin
      sig_tab[k]  = table_point(1'b0, longint'(k) * 1024 - 32768);
      tanh_tab[k] = table_point(1'b1, longint'(k) * 1024 - 32768);
    end
  end

  task automatic run_time_step();
    longint gates [GateRows];
    longint ax, ah, c, h;
    unit_result_t res;
    for (int r = 0; r < GateRows; r++) begin
      ax = longint'(biases[r]) * 4096;
      ah = longint'(biases[GateRows + r]) * 4096;
      for (int k = 0; k < InputSize; k++)
        ax += longint'(weights[r*RowLen + k]) * longint'(x_buf[k]);
      for (int k = 0; k < HiddenSize; k++)
        ah += longint'(weights[r*RowLen + InputSize + k]) * longint'(h_vec[k]);
      ax += rnd_q12(ah * longint'(gate_scale[r / HiddenSize]));
      gates[r] = activate(1'b0, rnd_q12(ax));
    end
    for (int j = 0; j < HiddenSize; j++) begin
      c = clamp16(rnd_q12(gates[HiddenSize + j] * longint'(c_vec[j])
                          + gates[j] * gates[2*HiddenSize + j]));
      h = clamp16(rnd_q12(gates[3*HiddenSize + j] * activate(1'b1, c)));
      c_vec[j] = c[15:0];
      h_vec[j] = h[15:0];
      res.hidden = h[15:0];
      res.cell_val = c[15:0];
      res.unit = j[4:0];
      res.last = (j == HiddenSize - 1);
      unit_results_q = {unit_results_q, res};
    end
  endtask

  task automatic report(input string field, input logic [15:0] exp_v,
                        input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    unit_result_t e;
    if (!rst_ni) begin
      for (int j = 0; j < HiddenSize; j++) begin
        h_vec[j] = '0;
        c_vec[j] = '0;
      end
      for (int g = 0; g < NumGates; g++) gate_scale[g] = 16'sd4096;
      unit_results_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) gate_scale[cfg_index_i] = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (unit_results_q.size() == 0) begin
          $display("%0t: unexpected result, unit %0d hidden %0h cell %0h", $time,
                   unit_index_i, hidden_value_i, cell_value_i);
          fail_count_o++;
        end else begin
          e = unit_results_q.pop_front();
          report("hidden_value", e.hidden, hidden_value_i);
          report("cell_value", e.cell_val, cell_value_i);
          report("unit_index", 16'(e.unit), 16'(unit_index_i));
          report("last_unit", 16'(e.last), 16'(last_unit_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (opcode_i)
          OP_WEIGHT: if (column_i < RowLen) weights[gate_row_i*RowLen + column_i] = value_i;
          OP_BIAS:   if (column_i < 2) biases[column_i*GateRows + gate_row_i] = value_i;
          OP_HIDDEN: if (gate_row_i < HiddenSize) h_vec[gate_row_i] = value_i;
          OP_CELL:   if (gate_row_i < HiddenSize) c_vec[gate_row_i] = value_i;
          OP_INPUT: begin
            if (column_i < InputSize) x_buf[column_i] = value_i;
            if (last_element_i) run_time_step();
          end
          default: ;
        endcase
      end
      pending_o <= unit_results_q.size();
    end
  end

endmodule

// File: bench/gate_scaled_lstm_cell_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gate_scaled_lstm_cell_test: stimulus and verdict for the LSTM cell
// Loads every weight, bias and input element, runs directed corner items and
// time steps under several gate scale settings, then random load and feed
// sequences with noise, with random gaps and output stalls on both sides.
// ----------------------------------------------------------------------------
module gate_scaled_lstm_cell_test;
  import glc_pkg::*;

  localparam int QuietLimit = 30000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SCALE_I;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = OP_WEIGHT;
  logic [6:0]  gate_row = '0;
  logic [5:0]  column = '0;
  logic [15:0] value = '0;
  logic        last_element = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] hidden_value, cell_value;
  logic [4:0]  unit_index;
  logic        last_unit;
  int          fail_count, pending;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;

  gate_scaled_lstm_cell dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .gate_row_i(gate_row), .column_i(column),
    .value_i(value), .last_element_i(last_element),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hidden_value_o(hidden_value), .cell_value_o(cell_value),
    .unit_index_o(unit_index), .last_unit_o(last_unit)
  );

  gate_scaled_lstm_cell_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .gate_row_i(gate_row), .column_i(column),
    .value_i(value), .last_element_i(last_element),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .hidden_value_i(hidden_value), .cell_value_i(cell_value),
    .unit_index_i(unit_index), .last_unit_i(last_unit),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stall for a random number of cycles, then take one slot
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      n = no_idle ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall = 1'b0;
      @(posedge clk_i);
    end
  end

  function automatic logic [15:0] draw_value();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [2:0] op, input logic [6:0] row,
                           input logic [5:0] col, input logic [15:0] val,
                           input logic last);
    int gap;
    if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    in_valid = 1'b0;
    repeat (gap) @(negedge clk_i);
    opcode = op;
    gate_row = row;
    column = col;
    value = val;
    last_element = last;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic write_scale(input cfg_index_e idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_we = 1'b1;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_scales(input logic [15:0] si, input logic [15:0] sf,
                            input logic [15:0] sg, input logic [15:0] so);
    write_scale(CFG_SCALE_I, si);
    write_scale(CFG_SCALE_F, sf);
    write_scale(CFG_SCALE_G, sg);
    write_scale(CFG_SCALE_O, so);
  endtask

  // wait until every predicted result is out and the block is quiet
  task automatic settle();
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic feed_step();
    for (int k = 0; k < InputSize; k++)
      send_item(OP_INPUT, 7'($urandom), 6'(k), draw_value(), k == InputSize - 1);
  endtask

  initial begin
    int items;
    int kind;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_scales(16'sd4096, 16'sd6144, 16'sd2048, 16'sd4096);

    // fill every store before the first step reads it
    for (int r = 0; r < GateRows; r++)
      for (int c = 0; c < RowLen; c++)
        send_item(OP_WEIGHT, 7'(r), 6'(c), draw_value(), 1'b0);
    for (int r = 0; r < GateRows; r++) begin
      send_item(OP_BIAS, 7'(r), 6'd0, draw_value(), 1'b0);
      send_item(OP_BIAS, 7'(r), 6'd1, draw_value(), 1'b0);
    end
    for (int k = 0; k < InputSize; k++)
      send_item(OP_INPUT, 7'($urandom), 6'(k), draw_value(), 1'b0);

    // directed corners
    send_item(OP_HIDDEN, 7'd0, 6'd0, 16'h7fff, 1'b0);
    send_item(OP_HIDDEN, 7'd31, 6'd63, 16'h8000, 1'b0);
    send_item(OP_CELL, 7'd0, 6'd0, 16'h7fff, 1'b0);
    send_item(OP_CELL, 7'd31, 6'd0, 16'h8000, 1'b0);
    send_item(OP_HIDDEN, 7'd127, 6'd5, 16'h1234, 1'b0);    // unit out of range
    send_item(OP_CELL, 7'd32, 6'd0, 16'h4321, 1'b0);
    send_item(OP_BIAS, 7'd3, 6'd63, 16'h7fff, 1'b0);       // bias column above one
    send_item(OP_BIAS, 7'd127, 6'd1, 16'h7fff, 1'b0);
    send_item(3'd5, 7'($urandom), 6'($urandom), 16'($urandom), 1'b1);
    send_item(3'd6, 7'($urandom), 6'($urandom), 16'($urandom), 1'b1);
    send_item(3'd7, 7'($urandom), 6'($urandom), 16'($urandom), 1'b1);
    send_item(OP_WEIGHT, 7'd127, 6'd63, 16'h8000, 1'b1);   // stray last mark
    send_item(OP_HIDDEN, 7'd5, 6'd0, 16'h0800, 1'b1);
    send_item(OP_INPUT, 7'd99, 6'd0, 16'h7fff, 1'b0);
    send_item(OP_INPUT, 7'd0, 6'd31, 16'h8000, 1'b0);
    send_item(OP_INPUT, 7'd127, 6'd63, 16'h1111, 1'b1);    // last mark, column out of range
    settle();
    set_scales(16'h7fff, 16'h8000, 16'h0000, 16'hf000);
    feed_step();
    settle();
    set_scales(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    feed_step();
    settle();

    // random load and feed sequences
    items = 0;
    while (items < 130) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 3))
            0: send_item(OP_WEIGHT, 7'($urandom), 6'($urandom), draw_value(), 1'($urandom));
            1: send_item(OP_BIAS, 7'($urandom), 6'($urandom_range(0, 1)), draw_value(), 1'b0);
            2: send_item(OP_HIDDEN, 7'($urandom_range(0, 31)), 6'($urandom), draw_value(), 1'b0);
            default: send_item(OP_CELL, 7'($urandom_range(0, 31)), 6'($urandom), draw_value(),
                               1'b0);
          endcase
          items++;
        end
        feed_step();
        items += InputSize;
      end else if (kind < 9) begin
        case ($urandom_range(0, 2))
          0: send_item(3'($urandom_range(5, 7)), 7'($urandom), 6'($urandom), 16'($urandom),
                       1'($urandom));
          1: send_item(OP_BIAS, 7'($urandom), 6'($urandom_range(2, 63)), 16'($urandom), 1'b0);
          default: send_item(OP_HIDDEN, 7'($urandom_range(32, 127)), 6'($urandom),
                             16'($urandom), 1'b0);
        endcase
      end else begin
        settle();
        set_scales(draw_value(), draw_value(), draw_value(), draw_value());
      end
    end

    settle();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
